// File: sv/gcd_pkg.sv
// Shared types and constants of the guided chunk dispenser.
`default_nettype none
package gcd_pkg;

    localparam int WORD_W    = 32;
    localparam int ID_W      = 6;
    localparam int WCNT_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LOWER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_UPPER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

// File: sv/guided_chunk_dispenser_top.sv
// Top level of the guided chunk dispenser: stream ports, configuration port, sequencer and datapath.
`default_nettype none
// Guided self-scheduling dispenser. Each request transfer on the slave stream asks for the
// next chunk of a loop for one worker; the block answers with one result transfer holding
// the first index of the chunk and one past its last index. The chunk size is the ceiling of
// the remaining iterations divided by the worker count (zero counts as one, values above
// MAX_WORKERS saturate). When nothing remains, start and end both equal the next index and
// the no-work flag is set; the index then holds. A request with begin_loop set restarts at
// loop_lower first. Writes to loop_lower or loop_upper never move the next index. A request
// with work left runs the restoring divider, which produces one quotient bit per cycle,
// before its result is written; a request with nothing left skips the divide steps. The
// next request is accepted once the result is written. The result sits in an output
// register, so a new request is taken while an earlier result still waits for its transfer.
// The user must write configuration only while the block is idle; the block does not
// enforce this. The configuration port is always ready and ignores unknown indexes.
module guided_chunk_dispenser_top #(
    parameter int MAX_WORKERS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [5:0] worker_id, [7:6] zero
    input  wire         i_s_tuser,   // [0] begin_loop
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [71:0] o_m_tdata,   // [5:0] served_worker, [37:6] chunk_start,
                                     // [69:38] chunk_end, [71:70] zero
    output logic        o_m_tuser,   // [0] no_work_left
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import gcd_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [ID_W-1:0]   served_worker;
    logic [WORD_W-1:0] chunk_start, chunk_end;
    logic              no_work_left;

    // Configuration writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;

    gcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gcd_dpath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_worker_id     (i_s_tdata[ID_W-1:0]),
        .i_begin_loop    (i_s_tuser),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_served_worker (served_worker),
        .o_chunk_start   (chunk_start),
        .o_chunk_end     (chunk_end),
        .o_no_work_left  (no_work_left)
    );

    // The padding bits of the result data carry nothing.
    assign o_m_tdata = {2'b00, chunk_end, chunk_start, served_worker};
    assign o_m_tuser = no_work_left;

endmodule
`default_nettype wire

// File: sv/gcd_ctrl.sv
// Sequencer of the guided chunk dispenser: request intake, divide steps, result slot.
`default_nettype none
module gcd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_out_ready,
    output logic             o_out_valid,
    output gcd_pkg::t_cmd    o_cmd,
    input  gcd_pkg::t_status i_status
);
    import gcd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (i_status.empty) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken result");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CALC))
        else $error("accepted request did not start the calculation");

    a_last_step_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step && i_status.div_last |=> (r_state == S_FIN))
        else $error("division end did not lead to the finish state");

endmodule
`default_nettype wire

// File: sv/gcd_dpath.sv
// Datapath of the guided chunk dispenser: settings, next index, divider, result register.
`default_nettype none
module gcd_dpath #(
    parameter int MAX_WORKERS = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [gcd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [gcd_pkg::WORD_W-1:0]            i_cfg_data,
    input  wire  [gcd_pkg::ID_W-1:0]              i_worker_id,
    input  wire                                   i_begin_loop,
    input  gcd_pkg::t_cmd                         i_cmd,
    output gcd_pkg::t_status                      o_status,
    output logic [gcd_pkg::ID_W-1:0]              o_served_worker,
    output logic [gcd_pkg::WORD_W-1:0]            o_chunk_start,
    output logic [gcd_pkg::WORD_W-1:0]            o_chunk_end,
    output logic                                  o_no_work_left
);
    import gcd_pkg::*;

    localparam int DW = $clog2(MAX_WORKERS + 1);
    localparam int CW = (DW > WCNT_W) ? DW : WCNT_W;

    logic [WORD_W-1:0] r_lower, r_upper, r_next;
    logic [WCNT_W-1:0] r_wcount;
    logic [ID_W-1:0]   r_wid;
    logic              r_empty;
    logic [WORD_W-1:0] r_quo;
    logic [DW-1:0]     r_rem, r_div;
    logic [CNT_W-1:0]  r_cnt;

    logic [WORD_W:0]   remain;
    logic [CW-1:0]     wc_ext, div_sat;
    logic [DW:0]       rem_sh, rem_sub;
    logic              ge;
    logic [WORD_W-1:0] chunk, end_raw, end_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= '0;
            r_upper  <= '0;
            r_wcount <= WCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOOP_LOWER:   r_lower  <= i_cfg_data;
                CFG_LOOP_UPPER:   r_upper  <= i_cfg_data;
                CFG_WORKER_COUNT: r_wcount <= i_cfg_data[WCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero workers count as one; counts above the limit saturate.
    always_comb begin
        wc_ext = CW'(r_wcount);
        if (wc_ext == '0) begin
            div_sat = CW'(1);
        end else if (wc_ext > CW'(MAX_WORKERS)) begin
            div_sat = CW'(MAX_WORKERS);
        end else begin
            div_sat = wc_ext;
        end
    end

    assign remain  = {r_upper[WORD_W-1], r_upper} - {r_next[WORD_W-1], r_next};
    assign rem_sh  = {r_rem, r_quo[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign ge      = (rem_sh >= {1'b0, r_div});

    // Ceiling of the quotient: one more when the division leaves a remainder.
    assign chunk     = r_quo + WORD_W'(r_rem != '0);
    assign end_raw   = r_next + chunk;
    assign end_clamp = ($signed(end_raw) > $signed(r_upper)) ? r_upper : end_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else if (i_cmd.load && i_begin_loop) begin
            r_next <= r_lower;
        end else if (i_cmd.finish && !r_empty) begin
            r_next <= end_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wid <= i_worker_id;
        end
        if (i_cmd.calc) begin
            r_empty <= remain[WORD_W] || (remain == '0);
            r_quo   <= remain[WORD_W-1:0];
            r_rem   <= '0;
            r_div   <= div_sat[DW-1:0];
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            o_served_worker <= r_wid;
            o_chunk_start   <= r_next;
            o_chunk_end     <= r_empty ? r_next : end_clamp;
            o_no_work_left  <= r_empty;
        end
    end

    assign o_status.empty    = r_empty;
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_div))
        else $error("partial remainder not below the divisor");

    a_end_within_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_empty) |-> ($signed(end_raw) <= $signed(r_upper)))
        else $error("chunk end beyond the loop upper bound");

    a_next_follows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_empty) |=> (r_next == o_chunk_end))
        else $error("next index does not follow the granted chunk");

endmodule
`default_nettype wire

// File: verif/chunk_grant_checker.sv
// Checker for the guided chunk dispenser: watches every channel, predicts each grant and compares it.
`timescale 1ns / 100ps
`default_nettype none
module chunk_grant_checker #(
    parameter int MAX_WORKERS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,
    input  wire         i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [71:0] i_m_tdata,
    input  wire         i_m_tuser,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import gcd_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]          served_worker;
        logic signed [WORD_W-1:0] chunk_start;
        logic signed [WORD_W-1:0] chunk_end;
        logic                     no_work_left;
    } t_chunk_grant;

    logic signed [WORD_W-1:0] loop_lower   = '0;
    logic signed [WORD_W-1:0] loop_upper   = '0;
    logic signed [WORD_W-1:0] next_index   = '0;
    logic [WCNT_W-1:0]        worker_count = WCNT_W'(1);
    t_chunk_grant             grants_due[$];
    int                       mismatches   = 0;

    // Guided self-scheduling: the chunk is the ceiling of the remaining span over the workers.
    function automatic t_chunk_grant grant_chunk(input logic [ID_W-1:0] wid,
                                                 input logic restart);
        t_chunk_grant grant;
        longint       share;
        longint       remain;
        longint       stop;
        if (worker_count == 0) begin
            share = 1;
        end else if (worker_count > MAX_WORKERS) begin
            share = MAX_WORKERS;
        end else begin
            share = worker_count;
        end
        if (restart) begin
            next_index = loop_lower;
        end
        remain = longint'(loop_upper) - longint'(next_index);
        grant.served_worker = wid;
        grant.chunk_start   = next_index;
        if (remain <= 0) begin
            grant.chunk_end    = next_index;
            grant.no_work_left = 1'b1;
        end else begin
            stop = longint'(next_index) + (remain + share - 1) / share;
            if (stop > longint'(loop_upper)) begin
                stop = longint'(loop_upper);
            end
            grant.chunk_end    = WORD_W'(stop);
            grant.no_work_left = 1'b0;
            next_index         = grant.chunk_end;
        end
        return grant;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_chunk_grant want;
        if (!i_rst_n) begin
            loop_lower   = '0;
            loop_upper   = '0;
            next_index   = '0;
            worker_count = WCNT_W'(1);
            grants_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOOP_LOWER:   loop_lower   = i_cfg_data;
                    CFG_LOOP_UPPER:   loop_upper   = i_cfg_data;
                    CFG_WORKER_COUNT: worker_count = i_cfg_data[WCNT_W-1:0];
                    default: ;
                endcase
            end
            // A result leaving now was granted at an earlier edge, so it is matched first.
            if (i_m_tvalid && i_m_tready) begin
                if (grants_due.size() == 0) begin
                    $error("result transfer with no chunk grant expected");
                    mismatches++;
                end else begin
                    want = grants_due.pop_front();
                    compare_field("served_worker", want.served_worker, i_m_tdata[5:0]);
                    compare_field("chunk_start", $signed(want.chunk_start),
                                  $signed(i_m_tdata[37:6]));
                    compare_field("chunk_end", $signed(want.chunk_end),
                                  $signed(i_m_tdata[69:38]));
                    compare_field("no_work_left", want.no_work_left, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                grants_due.push_back(grant_chunk(i_s_tdata[ID_W-1:0], i_s_tuser));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= grants_due.size();
    end

endmodule
`default_nettype wire

// File: verif/guided_chunk_dispenser_top_tb.sv
// Testbench top for the guided chunk dispenser: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps
`default_nettype none
module guided_chunk_dispenser_top_tb;
    import gcd_pkg::*;

    localparam int MAX_WORKERS = 64;
    // Minimum number of chunk requests, directed and random together; the last run may pass it.
    localparam int ITEM_TARGET = 1900;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int IDLE_LIMIT  = 3000;
    // Cycles to wait after the last result, well past the divider latency.
    localparam int TAIL_CYCLES = 40;
    // The block has three registers; the fourth index must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BLOCKS
    } ready_mode_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire         m_tuser;
    wire         cfg_ready;
    int          fail_count;
    int          pending;

    int          sent        = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    ready_mode_e ready_mode  = READY_ALWAYS;
    int          mode_left   = 0;
    int          hold_left   = 0;

    always #1 clk = ~clk;

    guided_chunk_dispenser_top #(
        .MAX_WORKERS(MAX_WORKERS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    chunk_grant_checker #(
        .MAX_WORKERS(MAX_WORKERS)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Sends one chunk request. The sender works in bursts; between bursts it drops
    // tvalid for a random gap, which lands on any cycle of the divider's work. Now and
    // then a long burst gives a stretch with no idling at all. The task returns at the
    // edge where the request transfer happened, so valid stays high for a following item.
    task automatic request(input logic [ID_W-1:0] wid, input logic restart);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wid};
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        sent++;
    endtask

    // Stops the sender and waits until every granted chunk has been received. The block
    // is idle afterwards, so registers may be written. At least one edge passes so that
    // the checker's count already includes the request just sent.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Holds a register write until its transfer. The caller lowers cfg_valid after the
    // last write of a batch, so back-to-back writes never toggle valid within one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // The receiver switches between stall patterns of its own: always ready, a coin flip,
    // rarely ready, and long blocks of ready or stalled.
    always @(posedge clk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= $urandom_range(0, 1);
            READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default: begin
                if (hold_left == 0) begin
                    m_tready  <= ~m_tready;
                    hold_left <= $urandom_range(1, 60);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("guided_chunk_dispenser_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0]          lo;
        logic [31:0]          hi;
        logic [31:0]          span;
        logic [31:0]          wc_data;
        logic [WCNT_W-1:0]    wc;
        logic [CFG_IDX_W-1:0] reg_order[3];
        logic [31:0]          reg_value[3];
        int                   first;
        int                   run_len;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: the loop is empty, so both requests come back
        // with no work left at index zero, with and without a restart.
        request(6'd63, 1'b0);
        request(6'd0, 1'b1);

        // Widest possible loop and a worker count of zero, which acts as one worker: the
        // first chunk covers the whole range and the next request finds nothing left.
        drain();
        write_reg(CFG_LOOP_LOWER, 32'h8000_0000);
        write_reg(CFG_LOOP_UPPER, 32'h7FFF_FFFF);
        write_reg(CFG_WORKER_COUNT, 32'd0);
        cfg_valid <= 1'b0;
        request(6'd5, 1'b1);
        request(6'd6, 1'b0);

        // A worker count above the maximum saturates; the loop ends at the top of the range.
        drain();
        write_reg(CFG_WORKER_COUNT, 32'd127);
        write_reg(CFG_LOOP_LOWER, 32'h7FFF_FF00);
        cfg_valid <= 1'b0;
        request(6'h2A, 1'b1);
        request(6'h15, 1'b0);
        request(6'd7, 1'b0);

        // Moving the lower bound and writing an unknown index must not disturb the loop
        // in progress: the next requests carry on from where it stood.
        drain();
        write_reg(CFG_LOOP_LOWER, 32'd0);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        request(6'd8, 1'b0);
        request(6'd9, 1'b0);

        // Upper bound below the lower bound, then equal to it: nothing to hand out.
        drain();
        write_reg(CFG_LOOP_LOWER, 32'd10);
        write_reg(CFG_LOOP_UPPER, 32'hFFFF_FFF6);
        write_reg(CFG_WORKER_COUNT, 32'd64);
        cfg_valid <= 1'b0;
        request(6'd3, 1'b1);
        drain();
        write_reg(CFG_LOOP_UPPER, 32'd10);
        cfg_valid <= 1'b0;
        request(6'd4, 1'b1);

        // A single iteration shared by the maximum number of workers.
        drain();
        write_reg(CFG_LOOP_LOWER, 32'd0);
        write_reg(CFG_LOOP_UPPER, 32'd1);
        cfg_valid <= 1'b0;
        request(6'd1, 1'b1);
        request(6'd2, 1'b0);

        // A loop across zero with three workers, so the ceiling rounds up on spans that three does not divide.
        drain();
        write_reg(CFG_LOOP_LOWER, 32'hFFFF_FFF9);
        write_reg(CFG_LOOP_UPPER, 32'd7);
        write_reg(CFG_WORKER_COUNT, 32'd3);
        cfg_valid <= 1'b0;
        request(6'd11, 1'b1);
        request(6'd12, 1'b0);
        request(6'd13, 1'b0);
        request(6'd14, 1'b0);

        // Random part. Each phase waits for all grants, reprograms the loop, and then runs
        // a sequence of random length that mostly starts with a restart. Spans are mostly
        // small so loops do run dry; a few are huge or inverted. A rare restart in
        // mid-sequence acts as noise.
        while (sent < ITEM_TARGET) begin
            drain();
            lo = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 2000)) - 32'd1000;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: span = $urandom_range(0, 300);
                6, 7:             span = $urandom_range(301, 200000);
                8:                span = -32'($urandom_range(0, 50));
                default:          span = $urandom() - lo;
            endcase
            hi = lo + span;
            case ($urandom_range(0, 9))
                0:       wc = '0;
                1:       wc = WCNT_W'($urandom_range(MAX_WORKERS + 1, 127));
                2:       wc = $urandom_range(0, 1) ? WCNT_W'(1) : WCNT_W'(MAX_WORKERS);
                default: wc = WCNT_W'($urandom_range(1, MAX_WORKERS));
            endcase
            // Bits above the register width are sometimes set; they must be dropped.
            wc_data = ($urandom_range(0, 3) == 0) ? (($urandom() & ~32'h7F) | wc) : 32'(wc);
            reg_order = '{CFG_LOOP_LOWER, CFG_LOOP_UPPER, CFG_WORKER_COUNT};
            reg_value = '{lo, hi, wc_data};
            first = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 9) != 0) begin
                    write_reg(reg_order[(first + k) % 3], reg_value[(first + k) % 3]);
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_UNUSED_INDEX, $urandom());
            end
            cfg_valid <= 1'b0;
            run_len = $urandom_range(4, 60);
            for (int j = 0; j < run_len; j++) begin
                request(ID_W'($urandom_range(0, 63)),
                        (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("guided_chunk_dispenser_top regression: pass");
        end else begin
            $display("guided_chunk_dispenser_top regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
